@@ hw/rtl/status_led_and_power_hold_controller_core_defines.svh @@
// Assertion helpers shared by the controller RTL.
`ifndef STATUS_LED_AND_POWER_HOLD_CONTROLLER_CORE_DEFINES_SVH
`define STATUS_LED_AND_POWER_HOLD_CONTROLLER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define SLPHC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// cond must never be true outside reset
`define SLPHC_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SLPHC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLPHC_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ hw/rtl/slphc_pkg.sv @@
package slphc_pkg;

    localparam logic [1:0] OP_UPDATE         = 2'd0;
    localparam logic [1:0] OP_UNREAD_CHANGED = 2'd1;
    localparam logic [1:0] OP_UNREAD_CLEARED = 2'd2;
    localparam logic [1:0] OP_START_SEQ      = 2'd3;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_HB_ON        = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HB_OFF       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEADUP_START = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEADUP_INT   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CONFIRM      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TONE_COUNT   = 3'd5;

    localparam logic [15:0] RST_HB_ON        = 16'd10;
    localparam logic [15:0] RST_HB_OFF       = 16'd3000;
    localparam logic [15:0] RST_LEADUP_START = 16'd1000;
    localparam logic [15:0] RST_LEADUP_INT   = 16'd1000;
    localparam logic [15:0] RST_CONFIRM      = 16'd5000;
    localparam logic [2:0]  RST_TONE_COUNT   = 3'd3;

    // dark gap between sequence steps
    localparam logic [7:0] SEQ_OFF_MS = 8'd47;

    localparam logic [1:0] TONE_NONE = 2'd0;
    localparam logic [1:0] TONE_LAST = 2'd3;

    // packed so that now_ms sits in the lowest bits
    typedef struct packed {
        logic [1:0]  opcode;
        logic        button_pressed;
        logic [15:0] unread_count;
        logic        link_connected;
        logic [1:0]  sequence_id;
        logic [31:0] now_ms;
    } t_item;

    localparam int ITEM_DATA_BITS = 52;
    localparam int IN_TDATA_BITS  = 56;

    typedef struct packed {
        logic        shutdown_request;
        logic [1:0]  tone_request;
        logic        yellow_led;
        logic        blue_led;
    } t_result;

    localparam int RESULT_BITS    = 5;
    localparam int OUT_TDATA_BITS = 8;

    typedef struct packed {
        logic [15:0] heartbeat_on_time;
        logic [15:0] heartbeat_off_time;
        logic [15:0] leadup_start_time;
        logic [15:0] leadup_interval;
        logic [15:0] confirm_hold_time;
        logic [2:0]  leadup_tone_count;
    } t_cfg;

    // blink sequence ROM: length, color (1 blue, 0 yellow) and on time per step
    function automatic logic [1:0] seq_len(input logic [1:0] sel);
        logic [1:0] len;
        unique case (sel)
            2'd0, 2'd1: len = 2'd2;
            default:    len = 2'd3;
        endcase
        return len;
    endfunction

    function automatic logic seq_is_blue(input logic [1:0] sel, input logic [1:0] pos);
        logic b;
        unique case ({sel, pos})
            4'b00_01, 4'b01_00, 4'b10_01, 4'b10_10, 4'b11_00: b = 1'b1;
            default: b = 1'b0;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] seq_on_ms(input logic [1:0] sel, input logic [1:0] pos);
        logic [7:0] ms;
        unique case ({sel, pos})
            4'b00_00, 4'b01_01, 4'b10_00, 4'b10_01, 4'b11_01, 4'b11_10: ms = 8'd94;
            4'b00_01, 4'b01_00, 4'b10_10, 4'b11_00:                     ms = 8'd188;
            default: ms = 8'd0;
        endcase
        return ms;
    endfunction

endpackage

@@ hw/rtl/slphc_engine.sv @@
module slphc_engine #(
    parameter int TIME_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  slphc_pkg::t_item  i_item,
    input  slphc_pkg::t_cfg   i_cfg,
    output slphc_pkg::t_result o_result
);

    localparam int EXT_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic                 r_blue, r_yellow;
    logic                 r_beat_cleared, r_beat_lit;
    logic [TIME_BITS-1:0] r_beat_dl;
    logic                 r_seq_active, r_seq_lit;
    logic [1:0]           r_seq_sel, r_seq_pos;
    logic [TIME_BITS-1:0] r_seq_dl;
    logic                 r_held, r_confirmed;
    logic [2:0]           r_tone_step;
    logic [TIME_BITS-1:0] r_press_time, r_tone_dl;

    logic                 n_blue, n_yellow;
    logic                 n_beat_cleared, n_beat_lit;
    logic [TIME_BITS-1:0] n_beat_dl;
    logic                 n_seq_active, n_seq_lit;
    logic [1:0]           n_seq_sel, n_seq_pos;
    logic [TIME_BITS-1:0] n_seq_dl;
    logic                 n_held, n_confirmed;
    logic [2:0]           n_tone_step;
    logic [TIME_BITS-1:0] n_press_time, n_tone_dl;

    logic [EXT_BITS-1:0]  w_now_ext;
    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_held_time;
    logic [TIME_BITS-1:0] w_at_leadup_start, w_at_leadup_int, w_at_hb_on, w_at_hb_off;
    logic [TIME_BITS-1:0] w_at_seq_off, w_at_seq_on;
    logic [TIME_BITS-1:0] w_diff_tone, w_diff_seq, w_diff_beat;
    logic                 w_tone_due, w_seq_wait, w_beat_wait;
    logic                 w_step_blue;
    logic [1:0]           w_len;
    logic [1:0]           w_tone;
    logic                 w_shutdown;
    logic                 w_act;

    assign w_now_ext   = EXT_BITS'(i_item.now_ms);
    assign w_now       = w_now_ext[TIME_BITS-1:0];
    assign w_held_time = w_now - r_press_time;

    assign w_at_leadup_start = w_now + TIME_BITS'(i_cfg.leadup_start_time);
    assign w_at_leadup_int   = w_now + TIME_BITS'(i_cfg.leadup_interval);
    assign w_at_hb_on        = w_now + TIME_BITS'(i_cfg.heartbeat_on_time);
    assign w_at_hb_off       = w_now + TIME_BITS'(i_cfg.heartbeat_off_time);
    assign w_at_seq_off      = w_now + TIME_BITS'(slphc_pkg::SEQ_OFF_MS);
    assign w_at_seq_on       = w_now + TIME_BITS'(slphc_pkg::seq_on_ms(r_seq_sel, r_seq_pos));

    // wraparound compare: deadline reached when now - deadline is not negative
    assign w_diff_tone = w_now - r_tone_dl;
    assign w_diff_seq  = w_now - r_seq_dl;
    assign w_diff_beat = w_now - r_beat_dl;
    assign w_tone_due  = (r_tone_dl != '0) && !w_diff_tone[TIME_BITS-1];
    assign w_seq_wait  = (r_seq_dl != '0) && w_diff_seq[TIME_BITS-1];
    assign w_beat_wait = (r_beat_dl != '0) && w_diff_beat[TIME_BITS-1];

    assign w_len       = slphc_pkg::seq_len(r_seq_sel);
    assign w_step_blue = slphc_pkg::seq_is_blue(r_seq_sel, r_seq_pos);

    always_comb begin
        n_blue         = r_blue;
        n_yellow       = r_yellow;
        n_beat_cleared = r_beat_cleared;
        n_beat_lit     = r_beat_lit;
        n_beat_dl      = r_beat_dl;
        n_seq_active   = r_seq_active;
        n_seq_lit      = r_seq_lit;
        n_seq_sel      = r_seq_sel;
        n_seq_pos      = r_seq_pos;
        n_seq_dl       = r_seq_dl;
        n_held         = r_held;
        n_confirmed    = r_confirmed;
        n_tone_step    = r_tone_step;
        n_press_time   = r_press_time;
        n_tone_dl      = r_tone_dl;
        w_tone         = slphc_pkg::TONE_NONE;
        w_shutdown     = 1'b0;
        w_act          = 1'b0;

        unique case (i_item.opcode)
            slphc_pkg::OP_UPDATE: begin
                // power button long press
                if (i_item.button_pressed && !r_held) begin
                    n_held       = 1'b1;
                    n_confirmed  = 1'b0;
                    n_tone_step  = '0;
                    n_press_time = w_now;
                    n_tone_dl    = w_at_leadup_start;
                end else if (i_item.button_pressed) begin
                    if (r_tone_step < i_cfg.leadup_tone_count && w_tone_due) begin
                        w_tone      = (r_tone_step >= 3'd2) ? slphc_pkg::TONE_LAST
                                                            : 2'(r_tone_step + 3'd1);
                        n_tone_step = r_tone_step + 3'd1;
                        n_tone_dl   = w_at_leadup_int;
                    end
                    if (!r_confirmed && w_held_time >= TIME_BITS'(i_cfg.confirm_hold_time))
                        n_confirmed = 1'b1;
                end else if (r_held) begin
                    w_shutdown   = r_confirmed;
                    n_held       = 1'b0;
                    n_confirmed  = 1'b0;
                    n_tone_step  = '0;
                    n_press_time = '0;
                    n_tone_dl    = '0;
                end

                // blink sequence
                if (!w_shutdown && (r_seq_active || r_seq_lit)) begin
                    if (w_seq_wait) begin
                        w_act = 1'b1;
                    end else if (r_seq_lit) begin
                        w_act     = 1'b1;
                        n_blue    = 1'b0;
                        n_yellow  = 1'b0;
                        n_seq_lit = 1'b0;
                        if (r_seq_pos >= w_len) begin
                            n_seq_active = 1'b0;
                            n_seq_sel    = '0;
                            n_seq_pos    = '0;
                            n_seq_dl     = '0;
                            n_beat_dl    = w_at_hb_off;
                        end else begin
                            n_seq_dl = w_at_seq_off;
                        end
                    end else if (r_seq_pos >= w_len) begin
                        n_seq_active = 1'b0;
                        n_seq_sel    = '0;
                        n_seq_pos    = '0;
                        n_seq_dl     = '0;
                    end else begin
                        w_act     = 1'b1;
                        n_blue    = w_step_blue;
                        n_yellow  = !w_step_blue;
                        n_seq_dl  = w_at_seq_on;
                        n_seq_pos = r_seq_pos + 2'd1;
                        n_seq_lit = 1'b1;
                    end
                end

                // unread heartbeat, only when no sequence step was handled
                if (!w_shutdown && !w_act) begin
                    if (i_item.link_connected || i_item.unread_count == '0 || r_beat_cleared) begin
                        if (r_beat_lit) begin
                            n_blue     = 1'b0;
                            n_beat_lit = 1'b0;
                        end
                        n_beat_dl = '0;
                    end else if (!w_beat_wait) begin
                        if (r_beat_lit) begin
                            n_blue     = 1'b0;
                            n_beat_lit = 1'b0;
                            n_beat_dl  = w_at_hb_off;
                        end else begin
                            n_blue     = 1'b1;
                            n_beat_lit = 1'b1;
                            n_beat_dl  = w_at_hb_on;
                        end
                    end
                end
            end
            slphc_pkg::OP_UNREAD_CHANGED, slphc_pkg::OP_UNREAD_CLEARED: begin
                n_beat_cleared = (i_item.opcode == slphc_pkg::OP_UNREAD_CLEARED);
                n_beat_lit     = 1'b0;
                n_beat_dl      = '0;
                n_blue         = 1'b0;
            end
            slphc_pkg::OP_START_SEQ: begin
                n_beat_lit   = 1'b0;
                n_beat_dl    = '0;
                n_seq_lit    = 1'b0;
                n_seq_active = 1'b1;
                n_seq_sel    = i_item.sequence_id;
                n_seq_pos    = '0;
                n_seq_dl     = '0;
                n_blue       = 1'b0;
                n_yellow     = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blue         <= 1'b0;
            r_yellow       <= 1'b0;
            r_beat_cleared <= 1'b0;
            r_beat_lit     <= 1'b0;
            r_beat_dl      <= '0;
            r_seq_active   <= 1'b0;
            r_seq_lit      <= 1'b0;
            r_seq_sel      <= '0;
            r_seq_pos      <= '0;
            r_seq_dl       <= '0;
            r_held         <= 1'b0;
            r_confirmed    <= 1'b0;
            r_tone_step    <= '0;
            r_press_time   <= '0;
            r_tone_dl      <= '0;
        end else if (i_en) begin
            r_blue         <= n_blue;
            r_yellow       <= n_yellow;
            r_beat_cleared <= n_beat_cleared;
            r_beat_lit     <= n_beat_lit;
            r_beat_dl      <= n_beat_dl;
            r_seq_active   <= n_seq_active;
            r_seq_lit      <= n_seq_lit;
            r_seq_sel      <= n_seq_sel;
            r_seq_pos      <= n_seq_pos;
            r_seq_dl       <= n_seq_dl;
            r_held         <= n_held;
            r_confirmed    <= n_confirmed;
            r_tone_step    <= n_tone_step;
            r_press_time   <= n_press_time;
            r_tone_dl      <= n_tone_dl;
        end
    end

    assign o_result.blue_led         = n_blue;
    assign o_result.yellow_led       = n_yellow;
    assign o_result.tone_request     = w_tone;
    assign o_result.shutdown_request = w_shutdown;

endmodule

@@ hw/rtl/status_led_and_power_hold_controller_core.sv @@
// Pipeline: an accepted item is held in the input register, its result in the result register.
// Throughput: one item per cycle unless the output stalls; the input register refills while a result waits.
// Timing path: one TIME_BITS-wide add and wraparound compare per deadline into the state.
// Reset (synchronous, active low): LEDs off, all timers unscheduled, config to defaults,
// both pipeline registers empty.
`include "status_led_and_power_hold_controller_core_defines.svh"

module status_led_and_power_hold_controller_core #(
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: now_ms[31:0], sequence_id[33:32], link_connected[34],
    //        unread_count[50:35], button_pressed[51], zero[55:52]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    // tdata: blue_led[0], yellow_led[1], tone_request[3:2], shutdown_request[4], zero[7:5]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    slphc_pkg::t_cfg    r_cfg;
    slphc_pkg::t_item   r_in_item;
    logic               r_in_valid;
    slphc_pkg::t_result r_out_result;
    logic               r_out_valid;

    slphc_pkg::t_result w_result;
    logic               w_out_free;
    logic               w_fire;
    logic               w_in_accept;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heartbeat_on_time  <= slphc_pkg::RST_HB_ON;
            r_cfg.heartbeat_off_time <= slphc_pkg::RST_HB_OFF;
            r_cfg.leadup_start_time  <= slphc_pkg::RST_LEADUP_START;
            r_cfg.leadup_interval    <= slphc_pkg::RST_LEADUP_INT;
            r_cfg.confirm_hold_time  <= slphc_pkg::RST_CONFIRM;
            r_cfg.leadup_tone_count  <= slphc_pkg::RST_TONE_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                slphc_pkg::CFG_HB_ON:        r_cfg.heartbeat_on_time  <= i_cfg_data;
                slphc_pkg::CFG_HB_OFF:       r_cfg.heartbeat_off_time <= i_cfg_data;
                slphc_pkg::CFG_LEADUP_START: r_cfg.leadup_start_time  <= i_cfg_data;
                slphc_pkg::CFG_LEADUP_INT:   r_cfg.leadup_interval    <= i_cfg_data;
                slphc_pkg::CFG_CONFIRM:      r_cfg.confirm_hold_time  <= i_cfg_data;
                slphc_pkg::CFG_TONE_COUNT:   r_cfg.leadup_tone_count  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready)
                r_in_valid <= s_axis_tvalid;
            if (w_out_free)
                r_out_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept)
            r_in_item <= {s_axis_tuser, s_axis_tdata[slphc_pkg::ITEM_DATA_BITS-1:0]};
        if (w_fire)
            r_out_result <= w_result;
    end

    slphc_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_fire),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(slphc_pkg::OUT_TDATA_BITS - slphc_pkg::RESULT_BITS)'(0), r_out_result};

    // a held item must not be dropped while the result side is stalled
    `SLPHC_ASSERT(a_in_hold, i_clk, i_rst_n, (r_in_valid && !w_fire) |=> r_in_valid, "input item lost while stalled")
    // every processed item produces a result in the next cycle
    `SLPHC_ASSERT(a_fire_out, i_clk, i_rst_n, w_fire |=> r_out_valid, "processed item produced no result")
    // a shutdown request only happens on release, never with a lead-up tone
    `SLPHC_NEVER(a_tone_shutdown, i_clk, i_rst_n, w_fire && w_result.shutdown_request && (w_result.tone_request != slphc_pkg::TONE_NONE), "tone and shutdown in one result")

endmodule
